// ===== hw/rtl/signed_int_to_padded_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the padded decimal ASCII converter
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is applied.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_PADDED_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_PADDED_DECIMAL_ASCII_MACROS_SVH

// Check a property on every clock edge outside reset
`define SIPDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define SIPDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define SIPDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sipda_pkg.sv =====
// ----------------------------------------------------------------------------
// sipda_pkg
// Types and constants shared by the controller and datapath of the
// signed integer to padded decimal ASCII converter.
// ----------------------------------------------------------------------------
package sipda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int DIGITS_MAX = 10;
    localparam int BCD_W      = 4 * DIGITS_MAX;
    localparam int ND_W       = 4;
    localparam int STEP_W     = 5;

    localparam logic [CHAR_W-1:0] CHR_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CONV  = 6'b000010,
        ST_SKIP  = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_SIGN  = 6'b010000,
        ST_DIGIT = 6'b100000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;       // capture a new request
        logic dabble;      // one shift-add-3 step
        logic skip;        // drop a leading zero digit
        logic calc_pad;    // compute the blank count
        logic emit_blank;  // load a blank into the output register
        logic emit_minus;  // load a minus sign
        logic emit_digit;  // load the leading digit
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic conv_done;   // the current step is the final binary bit
        logic lead_zero;   // leading digit is zero and more digits remain
        logic pad_zero;    // no blanks left
        logic out_free;    // output register can take a character
        logic neg;         // value is negative
        logic last_digit;  // one digit left
    } t_sts;

endpackage

// ===== hw/rtl/signed_int_to_padded_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_ascii
// Converts a signed 32-bit request into blank-padded decimal ASCII text,
// one character per output transfer.
// ----------------------------------------------------------------------------
// Each accepted value is sent as its decimal text, most significant character
// first: blanks on the left up to min_field_width (capped at MAX_WIDTH), then
// a minus sign for a negative value, then the digits; o_last_char marks the
// final digit. Text longer than the width is sent whole. One request is
// converted at a time: a bit-serial binary to BCD shift-add-3 loop runs first,
// then leading zeros are dropped, and the characters then leave one by one
// through the output register. Write i_cfg_data with i_cfg_we only while the
// block is idle.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_ascii #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sipda_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [sipda_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [sipda_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                 o_last_char
);

    sipda_pkg::t_cmd cmd;
    sipda_pkg::t_sts sts;

    // Sequencer
    sipda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Conversion datapath and output register
    sipda_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

// ===== hw/rtl/sipda_ctrl.sv =====
// ----------------------------------------------------------------------------
// sipda_ctrl
// Sequencer for the converter: runs the binary to BCD conversion, drops
// leading zeros, then emits blanks, the sign and the digits in order.
// ----------------------------------------------------------------------------
`include "signed_int_to_padded_decimal_ascii_macros.svh"

module sipda_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sipda_pkg::t_sts i_sts,
    output sipda_pkg::t_cmd o_cmd
);

    sipda_pkg::t_state r_state;
    sipda_pkg::t_state n_state;

    // Accept a new request only between conversions
    assign o_in_ready = (r_state == sipda_pkg::ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sipda_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = sipda_pkg::ST_CONV;
                end
            end
            sipda_pkg::ST_CONV: begin
                o_cmd.dabble = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = sipda_pkg::ST_SKIP;
                end
            end
            sipda_pkg::ST_SKIP: begin
                if (i_sts.lead_zero) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    o_cmd.calc_pad = 1'b1;
                    n_state        = sipda_pkg::ST_PAD;
                end
            end
            sipda_pkg::ST_PAD: begin
                if (i_sts.pad_zero) begin
                    n_state = i_sts.neg ? sipda_pkg::ST_SIGN : sipda_pkg::ST_DIGIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_blank = 1'b1;
                end
            end
            sipda_pkg::ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_minus = 1'b1;
                    n_state          = sipda_pkg::ST_DIGIT;
                end
            end
            sipda_pkg::ST_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state = sipda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sipda_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sipda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SIPDA_ASSERT(a_cmd_excl, i_clk, i_rst_n, $onehot0(o_cmd), "datapath commands overlap")
    `SIPDA_ASSERT_IMP(a_emit_free, i_clk, i_rst_n,
        o_cmd.emit_blank || o_cmd.emit_minus || o_cmd.emit_digit, i_sts.out_free,
        "character loaded while output register is occupied")
    `SIPDA_ASSERT_NXT(a_accept_conv, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == sipda_pkg::ST_CONV, "accepted request did not start conversion")

endmodule

// ===== hw/rtl/sipda_dp.sv =====
// ----------------------------------------------------------------------------
// sipda_dp
// Datapath: width register, magnitude shift register, BCD digit register
// with shift-add-3 lanes, blank counter and the output character register.
// ----------------------------------------------------------------------------
`include "signed_int_to_padded_decimal_ascii_macros.svh"

module sipda_dp #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sipda_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [sipda_pkg::VALUE_W-1:0] i_value,
    input  sipda_pkg::t_cmd                     i_cmd,
    output sipda_pkg::t_sts                     o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sipda_pkg::CHAR_W-1:0]        o_char_code,
    output logic                                o_last_char
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (PW > sipda_pkg::CFG_W) ? PW : sipda_pkg::CFG_W;
    localparam int BW = sipda_pkg::BCD_W;
    localparam int VW = sipda_pkg::VALUE_W;
    localparam int NW = sipda_pkg::ND_W;
    localparam int SW = sipda_pkg::STEP_W;

    logic [sipda_pkg::CFG_W-1:0]  r_width;
    logic                         r_neg;
    logic [VW-1:0]                r_bin;
    logic [BW-1:0]                r_bcd;
    logic [NW-1:0]                r_nd;
    logic [SW-1:0]                r_step;
    logic [PW-1:0]                r_pad;
    logic                         r_out_valid;
    logic [sipda_pkg::CHAR_W-1:0] r_char;
    logic                         r_last;

    logic                         n_neg;
    logic [VW-1:0]                n_bin;
    logic [BW-1:0]                n_bcd;
    logic [NW-1:0]                n_nd;
    logic [SW-1:0]                n_step;
    logic [PW-1:0]                n_pad;
    logic                         n_out_valid;
    logic [sipda_pkg::CHAR_W-1:0] n_char;
    logic                         n_last;

    logic [BW-1:0]                bcd_adj;
    logic [3:0]                   top_digit;
    logic [WW-1:0]                width_sat;
    logic [WW-1:0]                text_len;
    logic [WW-1:0]                pad_calc;
    logic                         out_free;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < sipda_pkg::DIGITS_MAX; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                          : r_bcd[4*i +: 4];
        end
    end

    assign top_digit = r_bcd[BW-1 -: 4];
    assign out_free  = !r_out_valid || i_out_ready;

    // Blank count: saturated width minus text length, floored at zero
    always_comb begin
        width_sat = (WW'(r_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_width);
        text_len  = WW'(r_nd) + WW'(r_neg);
        pad_calc  = (width_sat > text_len) ? (width_sat - text_len) : '0;
    end

    // Status to the controller
    always_comb begin
        o_sts.conv_done  = (r_step == SW'(VW - 1));
        o_sts.lead_zero  = (top_digit == 4'd0) && (r_nd > NW'(1));
        o_sts.pad_zero   = (r_pad == '0);
        o_sts.out_free   = out_free;
        o_sts.neg        = r_neg;
        o_sts.last_digit = (r_nd == NW'(1));
    end

    // Next values
    always_comb begin
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_nd        = r_nd;
        n_step      = r_step;
        n_pad       = r_pad;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        if (i_cmd.start) begin
            n_neg  = i_value[VW-1];
            n_bin  = i_value[VW-1] ? (VW'(0) - VW'(i_value)) : VW'(i_value);
            n_bcd  = '0;
            n_nd   = NW'(sipda_pkg::DIGITS_MAX);
            n_step = '0;
        end
        if (i_cmd.dabble) begin
            n_bcd  = {bcd_adj[BW-2:0], r_bin[VW-1]};
            n_bin  = {r_bin[VW-2:0], 1'b0};
            n_step = r_step + SW'(1);
        end
        if (i_cmd.skip) begin
            n_bcd = {r_bcd[BW-5:0], 4'd0};
            n_nd  = r_nd - NW'(1);
        end
        if (i_cmd.calc_pad) begin
            n_pad = PW'(pad_calc);
        end
        if (i_cmd.emit_blank) begin
            n_pad       = r_pad - PW'(1);
            n_out_valid = 1'b1;
            n_char      = sipda_pkg::CHR_BLANK;
            n_last      = 1'b0;
        end
        if (i_cmd.emit_minus) begin
            n_out_valid = 1'b1;
            n_char      = sipda_pkg::CHR_MINUS;
            n_last      = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_bcd       = {r_bcd[BW-5:0], 4'd0};
            n_nd        = r_nd - NW'(1);
            n_out_valid = 1'b1;
            n_char      = sipda_pkg::CHR_ZERO + {4'd0, top_digit};
            n_last      = (r_nd == NW'(1));
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_nd   <= n_nd;
        r_step <= n_step;
        r_pad  <= n_pad;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    `SIPDA_ASSERT_IMP(a_skip_zero, i_clk, i_rst_n, i_cmd.skip,
        top_digit == 4'd0 && r_nd > NW'(1), "non-zero or only digit dropped")
    `SIPDA_ASSERT_NXT(a_last_mark, i_clk, i_rst_n, i_cmd.emit_digit && r_nd == NW'(1),
        r_out_valid && r_last, "final digit not marked as last")
    `SIPDA_ASSERT_IMP(a_blank_cnt, i_clk, i_rst_n, i_cmd.emit_blank, r_pad != '0,
        "blank emitted with no blanks left")

endmodule
